// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stl_pkg.sv =====
package stl_pkg;

    // field widths
    localparam int TIME_W = 20;
    localparam int IDX_W  = 5;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 6;
    localparam int STAT_W = 3;

    localparam logic [TIME_W-1:0] MAX_TIME_RESET = TIME_W'(1000000);

    // request kinds
    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_CLR  = 2'd2,
        REQ_FIND = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_TOO_LARGE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_DUP       = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_BAD_INDEX = 3'd5
    } status_t;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_cmd_t;

endpackage

// ===== rtl/stl_cell.sv =====
module stl_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 6,
    parameter int XW    = 6
) (
    input  logic                      aclk,
    input  logic [CW-1:0]             count,
    input  logic                      cap,
    input  logic [stl_pkg::TIME_W-1:0] cmp_time,
    input  stl_pkg::cell_cmd_t        cmd,
    input  logic                      left_lt,
    input  logic [stl_pkg::TIME_W-1:0] left_time,
    input  logic [stl_pkg::TIME_W-1:0] right_time,
    input  logic [stl_pkg::TIME_W-1:0] ins_time,
    input  logic [XW-1:0]             del_idx,
    output logic [stl_pkg::TIME_W-1:0] time_q,
    output logic                      lt_q,
    output logic                      eq_q
);
    import stl_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic              lt_reg;
    logic              eq_reg;
    logic              valid;

    // entry is live when its slot is below the fill count
    assign valid = CW'(INDEX) < count;

    // compare flags taken when a request is accepted
    always_ff @(posedge aclk) begin
        if (cap) begin
            lt_reg <= valid && (time_reg < cmp_time);
            eq_reg <= valid && (time_reg == cmp_time);
        end
    end

    // shift up above the insert point, shift down from the removed slot
    always_ff @(posedge aclk) begin
        if (cmd.shift_up) begin
            if (!left_lt) begin
                time_reg <= left_time;
            end else if (!lt_reg) begin
                time_reg <= ins_time;
            end
        end else if (cmd.shift_down) begin
            if (XW'(INDEX) >= del_idx) begin
                time_reg <= right_time;
            end
        end
    end

    assign time_q = time_reg;
    assign lt_q   = lt_reg;
    assign eq_q   = eq_reg;

endmodule

// ===== rtl/sorted_time_list_unit.sv =====
// sorted time list built as a row of compare/shift cells, one cell per entry
// accept registers the request and the cell compare flags; execute shifts the cells
// and registers the result; no new request is accepted until the execute step is done
// the execute step waits while a previous result is still held in the output register
// reset (aresetn low, synchronous): list empty, max_time back to 1000000, no result pending
module sorted_time_list_unit #(
    parameter int LIST_SIZE = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wen,
    input  logic [stl_pkg::TIME_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,  // time_value[19:0], entry_index[24:20]
    input  logic [1:0]                 s_tuser,  // req_type[1:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,  // position[4:0], count[10:5]
    output logic [2:0]                 m_tuser   // status[2:0]
);
    import stl_pkg::*;

    localparam int IW = $clog2(LIST_SIZE);
    localparam int CW = $clog2(LIST_SIZE + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t            state_reg;
    logic [TIME_W-1:0] max_time_reg;
    logic [CW-1:0]     count_reg;
    req_t              req_type_reg;
    logic [TIME_W-1:0] req_time_reg;
    logic [IDX_W-1:0]  req_idx_reg;
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic [TIME_W-1:0]    cell_time [LIST_SIZE];
    logic [LIST_SIZE-1:0] cell_lt;
    logic [LIST_SIZE-1:0] cell_eq;
    logic [LIST_SIZE-1:0] lt_left;
    cell_cmd_t            cell_cmd;

    logic          s_accept;
    logic          exec_fire;
    logic [IW-1:0] ins_pos;
    logic          dup;
    logic          too_large;
    logic          full;
    logic          idx_bad;
    status_t       res_status;
    logic [IW-1:0] res_pos;
    logic [CW-1:0] count_next;
    logic          add_ok;
    logic          del_ok;

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    // left-neighbor flag, with a true flag entering the bottom of the row
    assign lt_left = {cell_lt[LIST_SIZE-2:0], 1'b1};

    // cell row
    for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
        logic [TIME_W-1:0] left_time;
        logic [TIME_W-1:0] right_time;

        if (i == 0) begin : g_first
            assign left_time = cell_time[i];
        end else begin : g_left
            assign left_time = cell_time[i-1];
        end

        if (i == LIST_SIZE - 1) begin : g_last
            assign right_time = cell_time[i];
        end else begin : g_right
            assign right_time = cell_time[i+1];
        end

        stl_cell #(
            .INDEX (i),
            .CW    (CW),
            .XW    (XW)
        ) u_cell (
            .aclk       (aclk),
            .count      (count_reg),
            .cap        (s_accept),
            .cmp_time   (s_tdata[TIME_W-1:0]),
            .cmd        (cell_cmd),
            .left_lt    (lt_left[i]),
            .left_time  (left_time),
            .right_time (right_time),
            .ins_time   (req_time_reg),
            .del_idx    (XW'(req_idx_reg)),
            .time_q     (cell_time[i]),
            .lt_q       (cell_lt[i]),
            .eq_q       (cell_eq[i])
        );
    end

    // lower-bound position from the edge of the less-than flags
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < LIST_SIZE; i++) begin
            if (!cell_lt[i] && lt_left[i]) begin
                ins_pos = ins_pos | IW'(i);
            end
        end
    end

    assign dup       = |cell_eq;
    assign too_large = req_time_reg > max_time_reg;
    assign full      = count_reg >= CW'(LIST_SIZE);
    assign idx_bad   = XW'(req_idx_reg) >= XW'(count_reg);

    // request decode
    always_comb begin
        res_status = STAT_OK;
        res_pos    = '0;
        count_next = count_reg;
        add_ok     = 1'b0;
        del_ok     = 1'b0;
        unique case (req_type_reg)
            REQ_ADD: begin
                if (too_large) begin
                    res_status = STAT_TOO_LARGE;
                end else if (full) begin
                    res_status = STAT_FULL;
                end else if (dup) begin
                    res_status = STAT_DUP;
                end else begin
                    res_pos    = ins_pos;
                    count_next = count_reg + CW'(1);
                    add_ok     = 1'b1;
                end
            end
            REQ_DEL: begin
                if (idx_bad) begin
                    res_status = STAT_BAD_INDEX;
                end else begin
                    count_next = count_reg - CW'(1);
                    del_ok     = 1'b1;
                end
            end
            REQ_CLR: begin
                count_next = '0;
            end
            REQ_FIND: begin
                if (too_large) begin
                    res_status = STAT_TOO_LARGE;
                end else if (dup) begin
                    res_pos = ins_pos;
                end else begin
                    res_status = STAT_NOT_FOUND;
                end
            end
            default: begin
                res_status = STAT_OK;
            end
        endcase
    end

    assign cell_cmd.shift_up   = exec_fire && add_ok;
    assign cell_cmd.shift_down = exec_fire && del_ok;

    // control state, request hold and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_time_reg <= MAX_TIME_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                max_time_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_fire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (exec_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            req_type_reg <= req_t'(s_tuser);
            req_time_reg <= s_tdata[TIME_W-1:0];
            req_idx_reg  <= s_tdata[TIME_W +: IDX_W];
        end
        if (exec_fire) begin
            m_status_reg <= res_status;
            m_pos_reg    <= POS_W'(res_pos);
            m_count_reg  <= CNT_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_count_reg, m_pos_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== rtl/stl_checker.sv =====
`include "assert_macros.svh"

module stl_checker #(
    parameter int LIST_SIZE = 32
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,  // position[4:0], count[10:5]
    input logic [2:0]  m_tuser   // status[2:0]
);
    import stl_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_SIZE);

    logic             s_acc;
    logic             m_wait;
    logic             m_err;
    logic             m_full;
    logic             m_done;
    logic [POS_W-1:0] m_pos;
    logic [CNT_W-1:0] m_cnt;
    logic [18:0]      m_bus;

    assign s_acc  = s_tvalid && s_tready;
    assign m_wait = m_tvalid && !m_tready;
    assign m_pos  = m_tdata[4:0];
    assign m_cnt  = m_tdata[10:5];
    assign m_bus  = {m_tuser, m_tdata};
    assign m_err  = m_tvalid && (m_tuser != STAT_OK);
    assign m_full = m_tvalid && (m_tuser == STAT_FULL);
    assign m_done = m_tvalid && m_tready && s_tready && !s_tvalid;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_wait, m_tvalid && $stable(m_bus), "result not held")

    // one request in flight at a time
    `ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_acc, !s_tready, "request taken while busy")

    // a refused or missed request reports position zero
    `ASSERT_IMPL(a_pos_zero, aclk, aresetn, m_err, m_pos == '0, "nonzero position on error")

    // a full report carries a full count
    `ASSERT_IMPL(a_full_count, aclk, aresetn, m_full, m_cnt == FULL_CNT, "short count on full")

    // after a result is taken with nothing in flight, the output goes empty
    `ASSERT_NEXT(a_out_drain, aclk, aresetn, m_done, !m_tvalid, "result repeated")

endmodule

bind sorted_time_list_unit stl_checker #(.LIST_SIZE(LIST_SIZE)) u_stl_checker (.*);
